// ----- rtl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, register indexes, command codes and constants of the trail
// tracker.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int RAD_W  = 52;
	localparam int ROOT_W = RAD_W / 2;

	localparam logic [23:0] MAX_LEN_RESET = 24'd25600;
	localparam logic [15:0] COS_RESET     = 16'd0;
	localparam logic [24:0] RUN_MAX       = 25'h1FFFFFF;
	localparam logic [23:0] TOT_MAX       = 24'hFFFFFF;
	localparam logic [16:0] FRAC_MAX      = 17'h1FFFF;

	localparam logic [0:0] REG_MAX_LEN = 1'b0;
	localparam logic [0:0] REG_COS     = 1'b1;

	localparam logic [1:0] ST_SKIP    = 2'd0;
	localparam logic [1:0] ST_APPEND  = 2'd1;
	localparam logic [1:0] ST_RESTART = 2'd2;

	typedef logic [3:0] op_t;

	localparam op_t OP_NONE     = 4'd0;
	localparam op_t OP_LOAD     = 4'd1;
	localparam op_t OP_SQX      = 4'd2;
	localparam op_t OP_SQY      = 4'd3;
	localparam op_t OP_SQGO     = 4'd4;
	localparam op_t OP_CAP      = 4'd5;
	localparam op_t OP_DOT1     = 4'd6;
	localparam op_t OP_DOT2     = 4'd7;
	localparam op_t OP_NLBL     = 4'd8;
	localparam op_t OP_CLO      = 4'd9;
	localparam op_t OP_CHI      = 4'd10;
	localparam op_t OP_CMP      = 4'd11;
	localparam op_t OP_RESTART  = 4'd12;
	localparam op_t OP_DROP     = 4'd13;
	localparam op_t OP_APPEND   = 4'd14;
	localparam op_t OP_DIV_INIT = 4'd15;

	typedef struct packed {
		op_t  op;
		logic sel_back;
		logic div_step;
		logic out_load;
		logic out_skip;
	} cmd_t;

	typedef struct packed {
		logic nl_zero;
		logic nl_short;
		logic bl_zero;
		logic sq_done;
		logic full;
		logic div_last;
		logic trim_need;
		logic out_full;
	} sts_t;

endpackage

// ----- rtl/polyline_trail_tracker_core.sv -----
// ----------------------------------------------------------------------------
// polyline_trail_tracker_core
// Trail of 2-D positions with segment lengths, turn test and length trim.
// ----------------------------------------------------------------------------
// One position is taken per beat and one result beat follows it. The new
// segment length is taken first: a short one is skipped, a zero one restarts
// the trail, and otherwise the previous segment length is taken and, unless
// it is zero, the turn test follows. A full ring drops its front point before
// the append, and trimming drops points from the front one at a time. The two
// segment lengths go through the shared iterative square root (squares, start
// and 26 root bits), the length fraction divider gives 17 quotient bits, and
// each trim waits on the registered read of the segment length memory.
// A new position is taken while the previous result still waits in the
// output register, but the next result is held back until that one has left.
module polyline_trail_tracker_core #(
	parameter int VERTEX_LIMIT = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // position_x, position_y
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // status, vertex_x, vertex_y, length_fraction,
	                                // removed_count, vertex_count, trail_total
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [23:0]  cfg_data
);

	ptt_pkg::cmd_t cmd;
	ptt_pkg::sts_t sts;

	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptt_datapath #(
		.VERTEX_LIMIT (VERTEX_LIMIT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- rtl/ptt_isqrt.sv -----
// ----------------------------------------------------------------------------
// ptt_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ptt_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ptt_pkg::RAD_W-1:0]      radicand,
	output logic [ptt_pkg::ROOT_W-1:0]     root,
	output logic                           done
);

	localparam int RW = ptt_pkg::ROOT_W;
	localparam int MW = RW + 2;
	localparam int CW = $clog2(RW);

	logic [ptt_pkg::RAD_W-1:0] rad_q;
	logic [MW-1:0]             rem_q;
	logic [RW-1:0]             root_q;
	logic [CW-1:0]             it_q;
	logic                      busy_q;
	logic                      done_q;

	logic [MW+1:0] rem2;
	logic [MW+1:0] trial;
	logic [MW+1:0] diff;
	logic          ge;

	assign rem2  = {rem_q, rad_q[ptt_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = rem2 >= trial;
	assign diff  = rem2 - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + CW'(1);
				if (it_q == CW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[ptt_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= ge ? diff[MW-1:0] : rem2[MW-1:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ----- rtl/ptt_datapath.sv -----
// ----------------------------------------------------------------------------
// ptt_datapath
// Registers, arithmetic, segment length memory and result register of the
// trail tracker, driven one command per cycle.
// ----------------------------------------------------------------------------
module ptt_datapath #(
	parameter int VERTEX_LIMIT = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ptt_pkg::cmd_t  cmd,
	output ptt_pkg::sts_t  sts,
	input  logic [47:0]    in_data,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_index,
	input  logic [23:0]    cfg_data,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [103:0]   m_tdata
);

	localparam int D  = VERTEX_LIMIT + 2;
	localparam int IW = $clog2(D);
	localparam int CW = $clog2(D + 1);
	localparam int AW = CW + 1;
	localparam int LG = $clog2(VERTEX_LIMIT + 1) - 1;

	function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] h, logic [CW-1:0] n);
		logic [AW-1:0] s;
		s = AW'(h) + AW'(n);
		if (s >= AW'(D))
			s = s - AW'(D);
		return s[IW-1:0];
	endfunction

	// configuration
	logic [23:0]        max_q;
	logic signed [15:0] cos_q;

	// step operands
	logic signed [23:0] px_q, py_q;
	logic signed [23:0] last_x_q, last_y_q, prev_x_q, prev_y_q;
	logic signed [24:0] nx_q, ny_q, bx_q, by_q;
	logic [49:0]        sqa_q, sqb_q;
	logic [25:0]        nl_q, bl_q;
	logic signed [49:0] pa_q, pb_q;
	logic signed [50:0] dot_q;
	logic [51:0]        pnb_q;
	logic signed [42:0] cl_q, ch_q;
	logic               rst_q;

	// trail state
	logic [IW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [24:0]   run_q;
	logic [CW-1:0] removed_q;
	logic [1:0]    status_q;

	logic [24:0]   seg_mem [D];
	logic [D-1:0]  seg_v_q;
	logic [24:0]   seg_rd_q;
	logic          seg_rv_q;

	// divider
	logic [23:0] rem_q;
	logic [16:0] quo_q;
	logic [3:0]  dcnt_q;
	logic        dsat_q;

	// result register
	logic         m_valid_q;
	logic [103:0] m_data_q;

	logic signed [23:0] in_x, in_y;
	logic [IW-1:0]      last_idx, nf_idx, slot_idx;
	logic signed [24:0] mul_a, mul_b;
	logic signed [49:0] mul_p;
	logic signed [15:0] cmul_a;
	logic signed [26:0] cmul_b;
	logic signed [42:0] cmul_p;
	logic [51:0]        pnb_w;
	logic [50:0]        sq_sum;
	logic [ptt_pkg::ROOT_W-1:0] root;
	logic               sq_done;
	logic signed [69:0] lhs_w, rhs_w;
	logic [23:0]        minlen;
	logic [26:0]        acc;
	logic [24:0]        run_add;
	logic [24:0]        seg_val;
	logic [24:0]        run_sub;
	logic               restart;
	logic               run_ge, div_sat;
	logic [24:0]        run_less;
	logic [24:0]        rem2, rem_sub;
	logic               rem_ge;
	logic [23:0]        total;
	logic [CW+5:0]      cnt_ext, rem_ext;
	logic               out_full;

	assign in_x     = in_data[23:0];
	assign in_y     = in_data[47:24];
	assign last_idx = wrap_add(head_q, CW'(cnt_q - CW'(1)));
	assign nf_idx   = wrap_add(head_q, CW'(1));
	assign slot_idx = wrap_add(head_q, cnt_q);

	always_comb begin
		mul_a = nx_q;
		mul_b = nx_q;
		case (cmd.op)
			ptt_pkg::OP_SQX: begin
				mul_a = cmd.sel_back ? bx_q : nx_q;
				mul_b = mul_a;
			end
			ptt_pkg::OP_SQY: begin
				mul_a = cmd.sel_back ? by_q : ny_q;
				mul_b = mul_a;
			end
			ptt_pkg::OP_DOT1: begin
				mul_a = nx_q;
				mul_b = bx_q;
			end
			ptt_pkg::OP_DOT2: begin
				mul_a = ny_q;
				mul_b = by_q;
			end
			default: begin
				mul_a = nx_q;
				mul_b = nx_q;
			end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign pnb_w  = nl_q * bl_q;
	assign cmul_a = cos_q;
	assign cmul_b = (cmd.op == ptt_pkg::OP_CHI) ? $signed({1'b0, pnb_q[51:26]})
		: $signed({1'b0, pnb_q[25:0]});
	assign cmul_p = cmul_a * cmul_b;
	assign sq_sum = {1'b0, sqa_q} + {1'b0, sqb_q};
	assign lhs_w  = 70'(dot_q) <<< 14;
	assign rhs_w  = (70'(ch_q) <<< 26) + 70'(cl_q);

	ptt_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == ptt_pkg::OP_SQGO),
		.radicand ({1'b0, sq_sum}),
		.root     (root),
		.done     (sq_done)
	);

	assign minlen   = max_q >> LG;
	assign acc      = {2'b00, run_q} + {1'b0, nl_q};
	assign run_add  = (acc > 27'(ptt_pkg::RUN_MAX)) ? ptt_pkg::RUN_MAX : acc[24:0];
	assign seg_val  = seg_rv_q ? seg_rd_q : 25'd0;
	assign run_sub  = (run_q >= seg_val) ? run_q - seg_val : 25'd0;
	assign restart  = (nl_q == '0) || rst_q;
	assign run_ge   = run_q >= {1'b0, max_q};
	assign div_sat  = (max_q == '0) || ({1'b0, run_q} >= {1'b0, max_q, 1'b0});
	assign run_less = run_q - {1'b0, max_q};
	assign rem2     = {rem_q, 1'b0};
	assign rem_ge   = rem2 >= {1'b0, max_q};
	assign rem_sub  = rem2 - {1'b0, max_q};
	assign total    = (run_q > 25'(ptt_pkg::TOT_MAX)) ? ptt_pkg::TOT_MAX : run_q[23:0];
	assign cnt_ext  = (CW + 6)'(cnt_q);
	assign rem_ext  = (CW + 6)'(removed_q);
	assign out_full = m_valid_q && !m_tready;

	always_comb begin
		sts.nl_zero   = nl_q == '0;
		sts.nl_short  = (nl_q != '0) && (nl_q < {2'b00, minlen});
		sts.bl_zero   = bl_q == '0;
		sts.sq_done   = sq_done;
		sts.full      = cnt_q >= CW'(D);
		sts.div_last  = dcnt_q == 4'd15;
		sts.trim_need = (run_q > {1'b0, max_q}) && (cnt_q > CW'(2));
		sts.out_full  = out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= ptt_pkg::MAX_LEN_RESET;
			cos_q <= ptt_pkg::COS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ptt_pkg::REG_MAX_LEN: max_q <= cfg_data;
				ptt_pkg::REG_COS:     cos_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// operand and arithmetic registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ptt_pkg::OP_LOAD: begin
				px_q <= in_x;
				py_q <= in_y;
				nx_q <= 25'(in_x) - 25'(last_x_q);
				ny_q <= 25'(in_y) - 25'(last_y_q);
				bx_q <= 25'(last_x_q) - 25'(prev_x_q);
				by_q <= 25'(last_y_q) - 25'(prev_y_q);
			end
			ptt_pkg::OP_SQX:  sqa_q <= $unsigned(mul_p);
			ptt_pkg::OP_SQY:  sqb_q <= $unsigned(mul_p);
			ptt_pkg::OP_CAP: begin
				if (cmd.sel_back)
					bl_q <= root;
				else
					nl_q <= root;
			end
			ptt_pkg::OP_DOT1: pa_q <= mul_p;
			ptt_pkg::OP_DOT2: pb_q <= mul_p;
			ptt_pkg::OP_NLBL: begin
				pnb_q <= pnb_w;
				dot_q <= 51'(pa_q) + 51'(pb_q);
			end
			ptt_pkg::OP_CLO: cl_q <= cmul_p;
			ptt_pkg::OP_CHI: ch_q <= cmul_p;
			ptt_pkg::OP_DIV_INIT: begin
				rem_q <= run_ge ? run_less[23:0] : run_q[23:0];
				quo_q <= {16'd0, run_ge};
			end
			default: ;
		endcase
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[23:0] : rem2[23:0];
			quo_q <= {quo_q[15:0], rem_ge};
		end
	end

	// trail state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			cnt_q     <= CW'(2);
			run_q     <= '0;
			removed_q <= '0;
			status_q  <= ptt_pkg::ST_APPEND;
			rst_q     <= 1'b0;
			dcnt_q    <= '0;
			dsat_q    <= 1'b0;
			seg_v_q   <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
		end else begin
			case (cmd.op)
				ptt_pkg::OP_LOAD: begin
					rst_q     <= 1'b0;
					removed_q <= '0;
					status_q  <= ptt_pkg::ST_APPEND;
				end
				ptt_pkg::OP_CMP: rst_q <= lhs_w < rhs_w;
				ptt_pkg::OP_RESTART: begin
					if (restart) begin
						head_q            <= last_idx;
						cnt_q             <= CW'(1);
						seg_v_q[last_idx] <= 1'b0;
						run_q             <= '0;
						status_q          <= ptt_pkg::ST_RESTART;
					end
				end
				ptt_pkg::OP_DROP: begin
					run_q           <= run_sub;
					seg_v_q[nf_idx] <= 1'b0;
					head_q          <= nf_idx;
					cnt_q           <= cnt_q - CW'(1);
					removed_q       <= removed_q + CW'(1);
				end
				ptt_pkg::OP_APPEND: begin
					seg_v_q[slot_idx] <= 1'b1;
					cnt_q             <= cnt_q + CW'(1);
					run_q             <= run_add;
					prev_x_q          <= last_x_q;
					prev_y_q          <= last_y_q;
					last_x_q          <= px_q;
					last_y_q          <= py_q;
				end
				ptt_pkg::OP_DIV_INIT: begin
					dcnt_q <= '0;
					dsat_q <= div_sat;
				end
				default: ;
			endcase
			if (cmd.div_step)
				dcnt_q <= dcnt_q + 4'd1;
		end
	end

	// segment length memory
	always_ff @(posedge clk) begin
		if (cmd.op == ptt_pkg::OP_APPEND)
			seg_mem[slot_idx] <= nl_q[24:0];
		seg_rd_q <= seg_mem[nf_idx];
		seg_rv_q <= seg_v_q[nf_idx];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_skip)
				m_data_q <= {1'b0, total, cnt_ext[5:0], 6'd0, 17'd0, 24'd0, 24'd0,
					ptt_pkg::ST_SKIP};
			else
				m_data_q <= {1'b0, total, cnt_ext[5:0], rem_ext[5:0],
					dsat_q ? ptt_pkg::FRAC_MAX : quo_q, py_q, px_q, status_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(1)) && (cnt_q <= CW'(D)))
		else $error("trail point count out of range");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < (IW + 1)'(D))
		else $error("head index beyond ring");

	a_trim_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !cmd.out_skip) |->
		((run_q <= {1'b0, max_q}) || (cnt_q == CW'(2))))
		else $error("result issued before trimming finished");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_full)
		else $error("result register overwritten");

endmodule

// ----- rtl/ptt_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptt_ctrl
// Sequencer of the trail tracker: steps the datapath through one item.
// ----------------------------------------------------------------------------
module ptt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  ptt_pkg::sts_t  sts,
	output ptt_pkg::cmd_t  cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_SQX    = 5'd1;
	localparam logic [4:0] S_SQY    = 5'd2;
	localparam logic [4:0] S_SQGO   = 5'd3;
	localparam logic [4:0] S_SQWAIT = 5'd4;
	localparam logic [4:0] S_DECIDE = 5'd5;
	localparam logic [4:0] S_BCHK   = 5'd6;
	localparam logic [4:0] S_DOT1   = 5'd7;
	localparam logic [4:0] S_DOT2   = 5'd8;
	localparam logic [4:0] S_NLBL   = 5'd9;
	localparam logic [4:0] S_CLO    = 5'd10;
	localparam logic [4:0] S_CHI    = 5'd11;
	localparam logic [4:0] S_CMP    = 5'd12;
	localparam logic [4:0] S_RST    = 5'd13;
	localparam logic [4:0] S_FULL   = 5'd14;
	localparam logic [4:0] S_FDROP  = 5'd15;
	localparam logic [4:0] S_APPEND = 5'd16;
	localparam logic [4:0] S_DIVI   = 5'd17;
	localparam logic [4:0] S_DIV    = 5'd18;
	localparam logic [4:0] S_TRIM   = 5'd19;
	localparam logic [4:0] S_TRD    = 5'd20;
	localparam logic [4:0] S_TDROP  = 5'd21;
	localparam logic [4:0] S_OUT    = 5'd22;
	localparam logic [4:0] S_SKIP   = 5'd23;

	logic [4:0] state_q, state_d;
	logic       phase_q, phase_d;

	assign s_tready = state_q == S_IDLE;

	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		cmd.op       = ptt_pkg::OP_NONE;
		cmd.sel_back = phase_q;
		cmd.div_step = 1'b0;
		cmd.out_load = 1'b0;
		cmd.out_skip = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = ptt_pkg::OP_LOAD;
					phase_d = 1'b0;
					state_d = S_SQX;
				end
			end
			S_SQX: begin
				cmd.op  = ptt_pkg::OP_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = ptt_pkg::OP_SQY;
				state_d = S_SQGO;
			end
			S_SQGO: begin
				cmd.op  = ptt_pkg::OP_SQGO;
				state_d = S_SQWAIT;
			end
			S_SQWAIT: begin
				if (sts.sq_done) begin
					cmd.op  = ptt_pkg::OP_CAP;
					state_d = phase_q ? S_BCHK : S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.nl_short) begin
					state_d = S_SKIP;
				end else if (sts.nl_zero) begin
					state_d = S_RST;
				end else begin
					phase_d = 1'b1;
					state_d = S_SQX;
				end
			end
			S_BCHK:   state_d = sts.bl_zero ? S_RST : S_DOT1;
			S_DOT1: begin
				cmd.op  = ptt_pkg::OP_DOT1;
				state_d = S_DOT2;
			end
			S_DOT2: begin
				cmd.op  = ptt_pkg::OP_DOT2;
				state_d = S_NLBL;
			end
			S_NLBL: begin
				cmd.op  = ptt_pkg::OP_NLBL;
				state_d = S_CLO;
			end
			S_CLO: begin
				cmd.op  = ptt_pkg::OP_CLO;
				state_d = S_CHI;
			end
			S_CHI: begin
				cmd.op  = ptt_pkg::OP_CHI;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.op  = ptt_pkg::OP_CMP;
				state_d = S_RST;
			end
			S_RST: begin
				cmd.op  = ptt_pkg::OP_RESTART;
				state_d = S_FULL;
			end
			// memory read of the front segment takes this cycle
			S_FULL:   state_d = sts.full ? S_FDROP : S_APPEND;
			S_FDROP: begin
				cmd.op  = ptt_pkg::OP_DROP;
				state_d = S_APPEND;
			end
			S_APPEND: begin
				cmd.op  = ptt_pkg::OP_APPEND;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.op  = ptt_pkg::OP_DIV_INIT;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_TRIM;
			end
			S_TRIM:   state_d = sts.trim_need ? S_TRD : S_OUT;
			S_TRD:    state_d = S_TDROP;
			S_TDROP: begin
				cmd.op  = ptt_pkg::OP_DROP;
				state_d = S_TRIM;
			end
			S_OUT: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SKIP: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					cmd.out_skip = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

// ----- bench/ptt_trail_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptt_trail_checker
// Watches the position, result and register ports of the trail tracker,
// keeps its own copy of the trail (points, segment lengths, running length)
// and compares every result beat field by field with the predicted one.
// ----------------------------------------------------------------------------
module ptt_trail_checker #(
	parameter int VERTEX_LIMIT = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [47:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [23:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           n_skip,
	output int           n_append,
	output int           n_restart,
	output int           max_removed
);

	localparam int DEPTH     = VERTEX_LIMIT + 2;
	localparam int LIM_LG    = $clog2(VERTEX_LIMIT + 1) - 1;
	localparam int EXP_DEPTH = 8;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] vx;
		logic [23:0] vy;
		logic [16:0] frac;
		logic [5:0]  removed;
		logic [5:0]  vcount;
		logic [23:0] total;
	} trail_res_t;

	logic signed [23:0] pt_x [DEPTH];
	logic signed [23:0] pt_y [DEPTH];
	logic [24:0]        seg_len [DEPTH];
	int                 head;
	int                 npts;
	logic [24:0]        run_len;
	logic [23:0]        max_len;
	logic signed [15:0] cos_lim;
	trail_res_t         exp_mem [EXP_DEPTH];
	int                 exp_wr;
	int                 exp_rd;
	int                 exp_fill;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [23:0] total_sat(input logic [24:0] v);
		return v > 25'(ptt_pkg::TOT_MAX) ? ptt_pkg::TOT_MAX : v[23:0];
	endfunction

	task automatic queue_result(input trail_res_t r);
		if (exp_fill >= EXP_DEPTH) begin
			$display("%0t: too many predicted beats, expected at most %0d, actual %0d",
				$time, EXP_DEPTH, exp_fill + 1);
			errors++;
		end else begin
			exp_mem[exp_wr] = r;
			exp_wr = (exp_wr + 1) % EXP_DEPTH;
			exp_fill++;
		end
	endtask

	task automatic drop_front();
		int nf;
		nf = (head + 1) % DEPTH;
		run_len = run_len >= seg_len[nf] ? run_len - seg_len[nf] : 25'd0;
		seg_len[nf] = 0;
		head = nf;
		npts--;
	endtask

	task automatic track_position(input logic signed [23:0] px, input logic signed [23:0] py);
		int                  last, prv, slot, removed;
		longint              bx, by, nx, ny, dot;
		logic [63:0]         nl, bl, acc, frac;
		logic signed [127:0] lhs, rhs, t;
		logic                restart;
		trail_res_t          r;
		last = (head + npts - 1) % DEPTH;
		prv  = (head + npts - 2) % DEPTH;
		nx = longint'(px) - longint'(pt_x[last]);
		ny = longint'(py) - longint'(pt_y[last]);
		bx = longint'(pt_x[last]) - longint'(pt_x[prv]);
		by = longint'(pt_y[last]) - longint'(pt_y[prv]);
		nl = int_sqrt(nx * nx + ny * ny);
		removed = 0;
		r = '0;
		if (nl > 0 && nl < 64'(max_len >> LIM_LG)) begin
			r.status = ptt_pkg::ST_SKIP;
			r.vcount = 6'(npts);
			r.total  = total_sat(run_len);
			queue_result(r);
			n_skip++;
			return;
		end
		restart = (nl == 0);
		if (!restart) begin
			bl = int_sqrt(bx * bx + by * by);
			if (bl != 0) begin
				dot = nx * bx + ny * by;
				lhs = dot;
				lhs = lhs * 16384;
				rhs = cos_lim;
				t = nl;
				rhs = rhs * t;
				t = bl;
				rhs = rhs * t;
				restart = lhs < rhs;
			end
		end
		if (restart) begin
			head = last;
			npts = 1;
			seg_len[last] = 0;
			run_len = 0;
			r.status = ptt_pkg::ST_RESTART;
			n_restart++;
		end else begin
			r.status = ptt_pkg::ST_APPEND;
			n_append++;
		end
		if (npts >= DEPTH) begin
			drop_front();
			removed++;
		end
		slot = (head + npts) % DEPTH;
		pt_x[slot] = px;
		pt_y[slot] = py;
		seg_len[slot] = nl[24:0];
		npts++;
		acc = 64'(run_len) + nl;
		run_len = acc > 64'(ptt_pkg::RUN_MAX) ? ptt_pkg::RUN_MAX : acc[24:0];
		if (max_len == 0) begin
			frac = 64'(ptt_pkg::FRAC_MAX);
		end else begin
			frac = (64'(run_len) << 16) / 64'(max_len);
			if (frac > 64'(ptt_pkg::FRAC_MAX)) frac = 64'(ptt_pkg::FRAC_MAX);
		end
		while (run_len > 25'(max_len) && npts > 2) begin
			drop_front();
			removed++;
		end
		if (removed > max_removed) max_removed = removed;
		r.vx = px;
		r.vy = py;
		r.frac = frac[16:0];
		r.removed = 6'(removed);
		r.vcount = 6'(npts);
		r.total = total_sat(run_len);
		queue_result(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, exp_v,
				act_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		trail_res_t e;
		trail_res_t a;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				pt_x[i] = 0;
				pt_y[i] = 0;
				seg_len[i] = 0;
			end
			head = 0;
			npts = 2;
			run_len = 0;
			max_len = ptt_pkg::MAX_LEN_RESET;
			cos_lim = ptt_pkg::COS_RESET;
			exp_wr = 0;
			exp_rd = 0;
			exp_fill = 0;
			errors = 0;
			pending = 0;
			n_skip = 0;
			n_append = 0;
			n_restart = 0;
			max_removed = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ptt_pkg::REG_MAX_LEN) max_len = cfg_data;
				else if (cfg_index == ptt_pkg::REG_COS) cos_lim = cfg_data[15:0];
			end
			if (m_tvalid && m_tready) begin
				a.status  = m_tdata[1:0];
				a.vx      = m_tdata[25:2];
				a.vy      = m_tdata[49:26];
				a.frac    = m_tdata[66:50];
				a.removed = m_tdata[72:67];
				a.vcount  = m_tdata[78:73];
				a.total   = m_tdata[102:79];
				if (exp_fill == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h",
						$time, m_tdata);
					errors++;
				end else begin
					e = exp_mem[exp_rd];
					exp_rd = (exp_rd + 1) % EXP_DEPTH;
					exp_fill--;
					check_field("status", e.status, a.status);
					check_field("vertex_x", e.vx, a.vx);
					check_field("vertex_y", e.vy, a.vy);
					check_field("length_fraction", e.frac, a.frac);
					check_field("removed_count", e.removed, a.removed);
					check_field("vertex_count", e.vcount, a.vcount);
					check_field("trail_total", e.total, a.total);
				end
			end
			if (s_tvalid && s_tready) track_position(s_tdata[23:0], s_tdata[47:24]);
			pending = exp_fill;
		end
	end

endmodule

// ----- bench/tb_polyline_trail_tracker_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyline_trail_tracker_core
// Drives positions and register writes into the trail tracker under random
// source gaps and sink stalls; a checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module tb_polyline_trail_tracker_core;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN      = 200;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [47:0]  s_tdata;   // position_x, position_y
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;   // status, vertex_x, vertex_y, length_fraction,
	                         // removed_count, vertex_count, trail_total
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [23:0]  cfg_data;
	int           errors, pending, n_skip, n_append, n_restart, max_removed;
	int           idle_cycles;
	int           n_sent;
	logic         src_quiet;
	logic         snk_quiet;
	logic signed [23:0] cur_x, cur_y;

	polyline_trail_tracker_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ptt_trail_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .n_skip(n_skip), .n_append(n_append),
		.n_restart(n_restart), .max_removed(max_removed)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// sink side: random stall before each beat, or none in quiet stretches
	initial begin
		int n;
		m_tready = 1'b0;
		@(negedge clk);
		forever begin
			n = snk_quiet ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_position(input logic signed [23:0] x, input logic signed [23:0] y);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {y, x};
		s_tvalid <= 1'b1;
		cur_x = x;
		cur_y = y;
		n_sent++;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// mostly a walk, steady heading, some zero, short, wild points, or unit x steps
	task automatic walk_phase(input logic [23:0] max_len, input int items, input int unit_step);
		int step_lo, step_hi, sx, sy, pick, mag;
		step_lo = (max_len >> 5) + 1;
		step_hi = step_lo * 3;
		sx = 1;
		sy = 1;
		for (int i = 0; i < items; i++) begin
			src_quiet = ($urandom_range(0, 3) == 0);
			snk_quiet = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (unit_step != 0) begin
				if (pick < 3) send_position(cur_x, cur_y);
				else send_position(24'(cur_x + 1), cur_y);
			end else if (pick < 8) begin
				send_position(cur_x, cur_y);
			end else if (pick < 16) begin
				mag = step_lo > 2 ? $urandom_range(1, step_lo - 2) : 1;
				send_position(24'(cur_x + mag), cur_y);
			end else if (pick < 28) begin
				send_position(24'($urandom), 24'($urandom));
			end else begin
				if ($urandom_range(0, 9) == 0) sx = -sx;
				if ($urandom_range(0, 9) == 0) sy = -sy;
				send_position(24'(cur_x + sx * int'($urandom_range(step_lo, step_hi))),
					24'(cur_y + sy * int'($urandom_range(0, step_lo))));
			end
		end
		drain();
	endtask

	initial begin
		logic [23:0] rnd_max;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = ptt_pkg::REG_MAX_LEN;
		cfg_data = '0;
		idle_cycles = 0;
		n_sent = 0;
		src_quiet = 1'b0;
		snk_quiet = 1'b0;
		cur_x = 0;
		cur_y = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero step, straight run, right angle, reversal, extremes, short step
		send_position(0, 0);
		send_position(256, 0);
		send_position(512, 0);
		send_position(512, 256);
		send_position(512, 0);
		send_position(24'sh7FFFFF, 24'sh7FFFFF);
		send_position(-24'sh800000, -24'sh800000);
		send_position(24'sh7FFFFF, -24'sh800000);
		send_position(-24'sh800000, 0);
		send_position(-24'sh7FFFFF, 0);
		send_position(0, 0);
		send_position(1000, 1000);
		send_position(2000, 2000);
		send_position(2010, 2000);
		drain();

		write_reg(ptt_pkg::REG_MAX_LEN, 24'd25600);
		write_reg(ptt_pkg::REG_COS, 24'd0);
		walk_phase(24'd25600, 100, 0);
		// tiny steps and a full turn allowed so the ring fills up
		write_reg(ptt_pkg::REG_MAX_LEN, 24'd63);
		write_reg(ptt_pkg::REG_COS, 24'(-16384));
		send_position(0, 0);
		walk_phase(24'd63, 90, 1);
		write_reg(ptt_pkg::REG_MAX_LEN, 24'd1);
		write_reg(ptt_pkg::REG_COS, 24'd16384);
		walk_phase(24'd1, 90, 0);
		write_reg(ptt_pkg::REG_MAX_LEN, 24'hFFFFFF);
		write_reg(ptt_pkg::REG_COS, 24'(-16384));
		walk_phase(24'hFFFFFF, 100, 0);
		write_reg(ptt_pkg::REG_COS, 24'd16384);
		walk_phase(24'hFFFFFF, 80, 0);
		write_reg(ptt_pkg::REG_MAX_LEN, 24'd4096);
		write_reg(ptt_pkg::REG_COS, 24'd11585);
		walk_phase(24'd4096, 100, 0);
		write_reg(ptt_pkg::REG_MAX_LEN, 24'h100000);
		write_reg(ptt_pkg::REG_COS, 24'(-8192));
		walk_phase(24'h100000, 100, 0);
		rnd_max = 24'($urandom_range(1, 24'hFFFFFF));
		write_reg(ptt_pkg::REG_MAX_LEN, rnd_max);
		write_reg(ptt_pkg::REG_COS, 24'(int'($urandom_range(0, 32768)) - 16384));
		walk_phase(rnd_max, 100, 0);

		$display("sent %0d positions: %0d skipped, %0d appended, %0d restarted",
			n_sent, n_skip, n_append, n_restart);
		$display("register settings 8, most front points dropped in one beat %0d",
			max_removed);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/ptt_pkg.sv
rtl/ptt_isqrt.sv
rtl/ptt_datapath.sv
rtl/ptt_ctrl.sv
rtl/polyline_trail_tracker_core.sv
bench/ptt_trail_checker.sv
bench/tb_polyline_trail_tracker_core.sv
